### design/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRC dither package
// Shared widths, register indexes, reset values and the pattern and
// configuration types used by the frame rate control dither.
// ----------------------------------------------------------------------------
package frc_pkg;

  // Channel value width on both sides of the block.
  localparam int CHAN_W = 16;

  // Default saturation cap on the output depth.
  localparam int MAX_CHANNEL_BITS_DEF = 16;

  // Configuration register width and index width.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Remainder compare width: covers every shift a CFG_W-bit depth can give.
  localparam int REM_W = 2 ** CFG_W;

  // One lane per color channel.
  localparam int NUM_LANES = 3;
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  // Phase counters run modulo six.
  localparam int PHASE_W   = 3;
  localparam int PHASE_MOD = 6;
  localparam int PSUM_W    = PHASE_W + 1;

  // Bit p is set where p mod 3 equals two, for a phase sum p of 0 to 15.
  localparam logic [2**PSUM_W-1:0] MOD3_IS_TWO = 16'h4924;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE = 2'd2;

  // Register values after reset.
  localparam logic [CFG_W-1:0] IN_BITS_RST  = 5'd8;
  localparam logic [CFG_W-1:0] OUT_BITS_RST = 5'd6;

  // Dither pattern selectors for the current pixel.
  typedef struct packed {
    logic even;     // phase sum mod 2 is zero
    logic m3_two;   // phase sum mod 3 is two
  } pat_t;

  // Live configuration.
  typedef struct packed {
    logic [CFG_W-1:0] in_bits;
    logic [CFG_W-1:0] out_bits;
    logic             gray;
  } cfg_t;

endpackage

### design/frc_spatiotemporal_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate control spatio-temporal dither
// Reduces RGB or gray pixels to a programmed bit depth with a phase-based
// dither pattern; three channel lanes feed a merging output register.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock while input ready is high and
// returns one beat per pixel, in order, through a lane register and then an
// output register. Each channel is handled by its own lane, which does the
// shift, dither and saturation combinationally into a lane register; the
// output register then merges the lanes. The two registers let a new pixel
// enter while a finished beat waits, and input ready drops only when both
// are full and the output is stalled. Row, column and frame phases advance on
// every accepted pixel from its line and frame end flags. Configuration writes
// are always ready and should be made only while no pixel is in flight.
// ----------------------------------------------------------------------------
module frc_spatiotemporal_dither #(
  parameter int MAX_CHANNEL_BITS = frc_pkg::MAX_CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Pixel input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [frc_pkg::CHAN_W-1:0]    in_red_in,
  input  logic [frc_pkg::CHAN_W-1:0]    in_green_in,
  input  logic [frc_pkg::CHAN_W-1:0]    in_blue_in,
  input  logic                          in_line_end,
  input  logic                          in_frame_end,
  // Pixel output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [frc_pkg::CHAN_W-1:0]    out_red_out,
  output logic [frc_pkg::CHAN_W-1:0]    out_green_out,
  output logic [frc_pkg::CHAN_W-1:0]    out_blue_out,
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frc_pkg::CFG_W-1:0]     cfg_data
);
  import frc_pkg::*;

  cfg_t                                cfg_r, cfg_nxt;
  pat_t                                pat;
  logic                                accept;
  logic                                lane_valid_r, lane_valid_nxt;
  logic                                take;
  logic [NUM_LANES-1:0][CHAN_W-1:0]    chan_in;
  logic [NUM_LANES-1:0][CHAN_W-1:0]    lane_res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IN_BITS:   cfg_nxt.in_bits  = cfg_data;
        CFG_OUT_BITS:  cfg_nxt.out_bits = cfg_data;
        CFG_GRAY_MODE: cfg_nxt.gray     = cfg_data[0];
        default:       cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_bits  <= IN_BITS_RST;
      cfg_r.out_bits <= OUT_BITS_RST;
      cfg_r.gray     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Lane stage occupancy and input handshake.
  assign in_ready = !lane_valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lane_valid_nxt = lane_valid_r;
    if (in_ready) begin
      lane_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_valid_r <= 1'b0;
    end else begin
      lane_valid_r <= lane_valid_nxt;
    end
  end

  // Phase counters and pattern selectors.
  frc_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (accept),
    .line_end  (in_line_end),
    .frame_end (in_frame_end),
    .pat       (pat)
  );

  // One lane per channel.
  assign chan_in[LANE_RED]   = in_red_in;
  assign chan_in[LANE_GREEN] = in_green_in;
  assign chan_in[LANE_BLUE]  = in_blue_in;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    frc_lane #(
      .MAX_CHANNEL_BITS (MAX_CHANNEL_BITS)
    ) u_lane (
      .clk     (clk),
      .load    (accept),
      .chan_in (chan_in[i]),
      .pat     (pat),
      .cfg     (cfg_r),
      .chan_r  (lane_res[i])
    );
  end

  // Merge and output register.
  frc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (lane_valid_r),
    .lane_res   (lane_res),
    .gray       (cfg_r.gray),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_red    (out_red_out),
    .out_green  (out_green_out),
    .out_blue   (out_blue_out),
    .take       (take)
  );

endmodule

### design/frc_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRC phase tracker
// Counts column, row and frame phases modulo six from the end flags and
// derives the dither pattern selectors for the pixel being accepted.
// ----------------------------------------------------------------------------
module frc_phase (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         line_end,
  input  logic         frame_end,
  output frc_pkg::pat_t pat
);
  import frc_pkg::*;

  logic [PHASE_W-1:0] col_r, col_nxt;
  logic [PHASE_W-1:0] row_r, row_nxt;
  logic [PHASE_W-1:0] frm_r, frm_nxt;
  logic [PSUM_W-1:0]  psum;

  function automatic logic [PHASE_W-1:0] wrap_inc(input logic [PHASE_W-1:0] x);
    logic [PHASE_W-1:0] y;
    y = (x == PHASE_W'(PHASE_MOD - 1)) ? '0 : x + PHASE_W'(1);
    return y;
  endfunction

  // The current pixel sees the phases from before its own update.
  always_comb begin
    psum = PSUM_W'(col_r) + PSUM_W'(row_r) + PSUM_W'(frm_r);
    pat.even   = ~psum[0];
    pat.m3_two = MOD3_IS_TWO[psum];
  end

  // Frame end wins over line end.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    frm_nxt = frm_r;
    if (adv) begin
      priority if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
        frm_nxt = wrap_inc(frm_r);
      end else if (line_end) begin
        col_nxt = '0;
        row_nxt = wrap_inc(row_r);
      end else begin
        col_nxt = wrap_inc(col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      frm_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      frm_r <= frm_nxt;
    end
  end

endmodule

### design/frc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRC channel lane
// Reduces or widens one channel value, applies the dither increment and
// saturates to the output depth, then registers the result.
// ----------------------------------------------------------------------------
module frc_lane #(
  parameter int MAX_CHANNEL_BITS = frc_pkg::MAX_CHANNEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [frc_pkg::CHAN_W-1:0]  chan_in,
  input  frc_pkg::pat_t               pat,
  input  frc_pkg::cfg_t               cfg,
  output logic [frc_pkg::CHAN_W-1:0]  chan_r
);
  import frc_pkg::*;

  localparam int LW = (MAX_CHANNEL_BITS > CHAN_W + 1) ? MAX_CHANNEL_BITS : CHAN_W + 1;
  localparam logic [CFG_W-1:0] CAP = CFG_W'(MAX_CHANNEL_BITS);

  logic [CFG_W-1:0]  eff_out;
  logic [LW:0]       lim_full;
  logic [LW-1:0]     limit;
  logic [CFG_W-1:0]  up_sh;
  logic [CFG_W-1:0]  dn_sh;
  logic              sat_up;
  logic [CHAN_W-1:0] up_val;
  logic [CHAN_W-1:0] up_res;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  half;
  logic [REM_W-1:0]  quarter;
  logic [REM_W-1:0]  three_q;
  logic              s_ge2;
  logic              inc;
  logic [CHAN_W-1:0] quo;
  logic [CHAN_W:0]   sum;
  logic              sat_dn;
  logic [CHAN_W-1:0] dn_res;
  logic [CHAN_W-1:0] chan_nxt;

  // Saturation limit from the capped output depth.
  always_comb begin
    eff_out  = (cfg.out_bits > CAP) ? CAP : cfg.out_bits;
    lim_full = ((LW + 1)'(1) << eff_out) - (LW + 1)'(1);
    limit    = lim_full[LW-1:0];
  end

  // Widening path: saturate when a set bit lands at or above eff_out.
  always_comb begin
    up_sh  = cfg.out_bits - cfg.in_bits;
    up_val = chan_in << up_sh;
    if (up_sh > eff_out) begin
      sat_up = (chan_in != '0);
    end else begin
      sat_up = ((chan_in >> (eff_out - up_sh)) != '0);
    end
    up_res = sat_up ? limit[CHAN_W-1:0] : up_val;
  end

  // Reducing path: remainder decides the dither increment.
  always_comb begin
    dn_sh   = cfg.in_bits - cfg.out_bits;
    rem     = REM_W'(chan_in) & ~({REM_W{1'b1}} << dn_sh);
    half    = REM_W'(1) << (dn_sh - CFG_W'(1));
    quarter = REM_W'(1) << (dn_sh - CFG_W'(2));
    three_q = REM_W'(3) << (dn_sh - CFG_W'(2));
    s_ge2   = (dn_sh >= CFG_W'(2));
    priority if (rem == half) begin
      inc = pat.even;
    end else if (s_ge2 && rem == quarter) begin
      inc = ~pat.m3_two;
    end else if (s_ge2 && rem == three_q) begin
      inc = pat.m3_two;
    end else begin
      inc = 1'b0;
    end
    quo    = chan_in >> dn_sh;
    sum    = {1'b0, quo} + (CHAN_W + 1)'(inc);
    sat_dn = (LW'(sum) > limit);
    dn_res = sat_dn ? limit[CHAN_W-1:0] : sum[CHAN_W-1:0];
  end

  assign chan_nxt = (cfg.in_bits <= cfg.out_bits) ? up_res : dn_res;

  // Lane result register.
  always_ff @(posedge clk) begin
    if (load) begin
      chan_r <= chan_nxt;
    end
  end

endmodule

### design/frc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRC lane merge
// Combines the three lane results into one output beat, replicating the
// red lane in gray mode, and holds the beat until it is taken.
// ----------------------------------------------------------------------------
module frc_merge (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           lane_valid,
  input  logic [frc_pkg::NUM_LANES-1:0][frc_pkg::CHAN_W-1:0] lane_res,
  input  logic                                           gray,
  input  logic                                           out_ready,
  output logic                                           out_valid,
  output logic [frc_pkg::CHAN_W-1:0]                     out_red,
  output logic [frc_pkg::CHAN_W-1:0]                     out_green,
  output logic [frc_pkg::CHAN_W-1:0]                     out_blue,
  output logic                                           take
);
  import frc_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;

  // The output register loads a waiting lane result whenever it is empty or being drained.
  assign take = lane_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload; gray mode copies the red lane to every channel.
  always_ff @(posedge clk) begin
    if (take) begin
      red_r   <= lane_res[LANE_RED];
      green_r <= gray ? lane_res[LANE_RED] : lane_res[LANE_GREEN];
      blue_r  <= gray ? lane_res[LANE_RED] : lane_res[LANE_BLUE];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

### design/frc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRC dither port checker
// Watches the top-level ports for occupancy, stall behavior, gray-mode
// replication and the output depth bound.
// ----------------------------------------------------------------------------
module frc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [frc_pkg::CHAN_W-1:0]    out_red_out,
  input logic [frc_pkg::CHAN_W-1:0]    out_green_out,
  input logic [frc_pkg::CHAN_W-1:0]    out_blue_out,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [frc_pkg::CFG_W-1:0]     cfg_data
);
  import frc_pkg::*;

  logic [1:0]       cnt_r, cnt_nxt;
  logic             gray_r;
  logic [CFG_W-1:0] obits_r;
  logic             cfg_wr;

  // Beats in flight inside the block.
  always_comb begin
    cnt_nxt = cnt_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
  end

  // Shadow copies of the gray flag and the output depth.
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      gray_r  <= 1'b0;
      obits_r <= OUT_BITS_RST;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_wr && cfg_index == CFG_GRAY_MODE) begin
        gray_r <= cfg_data[0];
      end
      if (cfg_wr && cfg_index == CFG_OUT_BITS) begin
        obits_r <= cfg_data;
      end
    end
  end

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out))
    else $error("output beat changed while stalled");

  // At most two beats in flight, and a shown beat was accepted.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3 && (!out_valid || cnt_r != 2'd0))
    else $error("in-flight beat count out of range");

  // An empty block takes input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> in_ready)
    else $error("input not ready while empty");

  // Gray mode drives one value on all three channels.
  a_gray_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gray_r |-> out_red_out == out_green_out &&
      out_green_out == out_blue_out)
    else $error("gray output not replicated");

  // No output bit at or above the programmed depth.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && obits_r < CFG_W'(CHAN_W) |->
      (out_red_out >> obits_r) == '0 && (out_green_out >> obits_r) == '0 &&
      (out_blue_out >> obits_r) == '0)
    else $error("output exceeds programmed depth");

endmodule

bind frc_spatiotemporal_dither frc_checker u_frc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data)
);

### test/frc_dither_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRC dither checker
// Watches the pixel, result and register channels of the dither block. It
// keeps its own copy of the depth registers and the row, column and frame
// phases, works out the dithered pixel for every accepted input beat and
// compares each output beat, channel by channel, with the oldest one.
// ----------------------------------------------------------------------------
module frc_dither_checker
  import frc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CHAN_W-1:0]    in_red_in,
  input  logic [CHAN_W-1:0]    in_green_in,
  input  logic [CHAN_W-1:0]    in_blue_in,
  input  logic                 in_line_end,
  input  logic                 in_frame_end,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [CHAN_W-1:0]    out_red_out,
  input  logic [CHAN_W-1:0]    out_green_out,
  input  logic [CHAN_W-1:0]    out_blue_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  cfg_t             depth_cfg;
  logic [PHASE_W-1:0] col_ph;
  logic [PHASE_W-1:0] row_ph;
  logic [PHASE_W-1:0] frame_ph;
  rgb_t             expected_pixels[$];
  int               accepted_beats;
  int               returned_beats;

  assign pending = accepted_beats - returned_beats;

  // Shift one channel to the output depth, add the pattern bit for an exact
  // half, quarter or three-quarter remainder, then saturate.
  function automatic logic [CHAN_W-1:0] dither_value(input cfg_t c,
                                                     input logic [CHAN_W-1:0] v,
                                                     input int psum);
    logic [63:0] wide;
    logic [63:0] frac;
    logic [63:0] limit;
    int unsigned ib;
    int unsigned ob;
    int unsigned cap;
    int unsigned s;
    ib = c.in_bits;
    ob = c.out_bits;
    cap = (ob > MAX_CHANNEL_BITS_DEF) ? MAX_CHANNEL_BITS_DEF : ob;
    limit = (64'd1 << cap) - 64'd1;
    if (ib <= ob) begin
      wide = 64'(v) << (ob - ib);
    end else begin
      s = ib - ob;
      frac = 64'(v) & ((64'd1 << s) - 64'd1);
      wide = 64'(v) >> s;
      if (frac == (64'd1 << (s - 1))) begin
        if (psum % 2 == 0) wide = wide + 64'd1;
      end else if (s >= 2 && frac == (64'd1 << (s - 2))) begin
        if (psum % 3 != 2) wide = wide + 64'd1;
      end else if (s >= 2 && frac == (64'd3 << (s - 2))) begin
        if (psum % 3 == 2) wide = wide + 64'd1;
      end
    end
    if (wide > limit) wide = limit;
    return wide[CHAN_W-1:0];
  endfunction

  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
    return (ph == PHASE_W'(PHASE_MOD - 1)) ? '0 : ph + 1'b1;
  endfunction

  // Count a wrong channel; only the first few are described.
  task automatic flag_channel(input string chan, input logic [CHAN_W-1:0] want,
                              input logic [CHAN_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch at beat %0d, %s: expected %h, got %h",
                 returned_beats, chan, want, got);
    end
  endtask

  // Mirror registers and phases, queue predictions and check output beats.
  always @(posedge clk) begin : track
    rgb_t want;
    int   psum;
    if (!rst_n) begin
      depth_cfg = '{in_bits: IN_BITS_RST, out_bits: OUT_BITS_RST, gray: 1'b0};
      col_ph = '0;
      row_ph = '0;
      frame_ph = '0;
      expected_pixels.delete();
      mismatches = 0;
      accepted_beats <= 0;
      returned_beats <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IN_BITS:   depth_cfg.in_bits = cfg_data;
          CFG_OUT_BITS:  depth_cfg.out_bits = cfg_data;
          CFG_GRAY_MODE: depth_cfg.gray = cfg_data[0];
          default: ;
        endcase
      end

      // The pixel uses the phases from before its own flags take effect.
      if (in_valid && in_ready) begin
        psum = int'(col_ph) + int'(row_ph) + int'(frame_ph);
        want.red = dither_value(depth_cfg, in_red_in, psum);
        if (depth_cfg.gray) begin
          want.green = want.red;
          want.blue = want.red;
        end else begin
          want.green = dither_value(depth_cfg, in_green_in, psum);
          want.blue = dither_value(depth_cfg, in_blue_in, psum);
        end
        expected_pixels.push_back(want);
        if (in_frame_end) begin
          col_ph = '0;
          row_ph = '0;
          frame_ph = next_phase(frame_ph);
        end else if (in_line_end) begin
          col_ph = '0;
          row_ph = next_phase(row_ph);
        end else begin
          col_ph = next_phase(col_ph);
        end
        accepted_beats <= accepted_beats + 1;
      end

      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Output beat with no pixel waiting: %h %h %h",
                     out_red_out, out_green_out, out_blue_out);
        end else begin
          want = expected_pixels.pop_front();
          flag_channel("red", want.red, out_red_out);
          flag_channel("green", want.green, out_green_out);
          flag_channel("blue", want.blue, out_blue_out);
          returned_beats <= returned_beats + 1;
        end
      end
    end
  end

endmodule

### test/frc_spatiotemporal_dither_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FRC dither testbench
// Drives pixels and depth register writes into the dither block while a
// checker beside it predicts every output pixel. A short directed run hits
// the exact half, quarter and three-quarter remainders, saturation, shifts
// up and down, zero depth and gray mode; random segments follow under a
// range of depth settings and idle mixes, including long output stalls.
// ----------------------------------------------------------------------------
module frc_spatiotemporal_dither_tb;
  import frc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int LONG_HOLD  = 300;
  localparam int SEG_PIXELS = 44;
  localparam int SEGMENTS   = 12;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [CHAN_W-1:0]    in_red_in = '0;
  logic [CHAN_W-1:0]    in_green_in = '0;
  logic [CHAN_W-1:0]    in_blue_in = '0;
  logic                 in_line_end = 1'b0;
  logic                 in_frame_end = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IN_BITS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic [CHAN_W-1:0]    out_red_out;
  logic [CHAN_W-1:0]    out_green_out;
  logic [CHAN_W-1:0]    out_blue_out;
  logic                 cfg_ready;
  int                   mismatches;
  int                   pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int cur_in = 8;
  int cur_out = 6;
  int pixels_sent = 0;
  int settings_used = 0;
  int col_pos = 0;
  int row_pos = 0;
  int row_len = 4;
  int frame_rows = 3;

  int seg_in  [SEGMENTS] = '{8, 16, 16, 10, 1, 31, 16, 12, 0, 14, 5, 0};
  int seg_out [SEGMENTS] = '{6, 1, 8, 8, 16, 4, 16, 3, 31, 13, 0, 0};
  bit seg_gray[SEGMENTS] = '{0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 1, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frc_spatiotemporal_dither uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_line_end  (in_line_end),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frc_dither_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_line_end  (in_line_end),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Output side: random backpressure, or a long hold when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        holds_done++;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(2_000_000);
    $display("Timeout with %0d pixels still outstanding.", pending);
    $display("** frc_spatiotemporal_dither: FAILED **");
    $finish;
  end

  // Offer one pixel beat, after an optional random gap, and wait for it.
  task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic le,
                            input logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_line_end <= le;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // Stop offering pixels and let every outstanding pixel come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(data);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_depths(input int ib, input int ob, input bit gray);
    wait_idle();
    write_reg(CFG_IN_BITS, ib);
    write_reg(CFG_OUT_BITS, ob);
    write_reg(CFG_GRAY_MODE, int'(gray));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_in = ib;
    cur_out = ob;
    settings_used++;
  endtask

  // Channel value biased toward the remainders that trigger the pattern.
  function automatic logic [CHAN_W-1:0] pick_channel(input int s);
    logic [63:0] v;
    int          kind;
    v = 64'($urandom_range(16'hFFFF));
    kind = $urandom_range(7);
    if (s > 0 && kind < 5) begin
      v = v & ~((64'd1 << s) - 64'd1);
      case (kind)
        0: v = v | (64'd1 << (s - 1));
        1: if (s >= 2) v = v | (64'd1 << (s - 2));
        2: if (s >= 2) v = v | (64'd3 << (s - 2));
        3: v = v | (64'($urandom) & ((64'd1 << s) - 64'd1));
        default: ;
      endcase
    end else if (kind == 5) begin
      v = 64'hFFFF;
    end else if (kind == 6) begin
      // Just around the top of the input depth, above it included.
      v = (64'd1 << cur_in) + 64'($urandom_range(3)) - 64'd2;
    end
    return v[CHAN_W-1:0];
  endfunction

  // Mostly well-formed rows and frames, with an occasional stray flag.
  task automatic send_random_pixel();
    int  s;
    logic le;
    logic fe;
    s = cur_in - cur_out;
    if ($urandom_range(15) == 0) begin
      le = 1'($urandom_range(1));
      fe = 1'($urandom_range(1));
    end else begin
      le = (col_pos == row_len - 1);
      fe = le && (row_pos == frame_rows - 1);
      col_pos = le ? 0 : col_pos + 1;
      row_pos = fe ? 0 : (le ? row_pos + 1 : row_pos);
      if (fe) begin
        row_len = $urandom_range(1, 7);
        frame_rows = $urandom_range(1, 6);
      end
    end
    send_pixel(pick_channel(s), pick_channel(s), pick_channel(s), le, fe);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset depths, eight to six bits: each remainder class at several phases.
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'h0002, 16'h0001, 16'h0003, 1'b0, 1'b0);
    send_pixel(16'h0002, 16'h0001, 16'h0003, 1'b0, 1'b0);
    send_pixel(16'h00FF, 16'h00FE, 16'h00FD, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 16'h8000, 16'h0100, 1'b0, 1'b0);
    send_pixel(16'h0006, 16'h0005, 16'h0007, 1'b1, 1'b1);
    send_pixel(16'h0002, 16'h0001, 16'h0003, 1'b0, 1'b0);

    // Gray mode with a wide shift; green and blue must be ignored.
    set_depths(16, 8, 1'b1);
    send_pixel(16'h1280, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'h1240, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'h12C0, 16'h5555, 16'hAAAA, 1'b0, 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0);

    // A write to the spare index must change nothing.
    set_depths(16, 8, 1'b0);
    write_reg(CFG_SPARE_IDX, 31);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_pixel(16'h0080, 16'h0040, 16'h00C0, 1'b0, 1'b0);

    // One-bit shift: only the half remainder applies.
    set_depths(9, 8, 1'b0);
    send_pixel(16'h0001, 16'h0003, 16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'h0001, 16'h0003, 16'h5555, 1'b0, 1'b0);

    // Widening by fifteen bits, with saturation at sixteen.
    set_depths(1, 16, 1'b0);
    send_pixel(16'h0001, 16'hFFFF, 16'h8000, 1'b0, 1'b0);
    send_pixel(16'h0000, 16'h0002, 16'h7FFF, 1'b1, 1'b0);

    // Zero output depth clamps everything to zero.
    set_depths(31, 0, 1'b0);
    send_pixel(16'hFFFF, 16'h8000, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'h4000, 16'h0001, 16'hFFFF, 1'b0, 1'b1);

    // Zero input depth, output depth above the channel width.
    set_depths(0, 31, 1'b0);
    send_pixel(16'h0001, 16'h0000, 16'hFFFF, 1'b0, 1'b0);

    // Equal depths pass values through.
    set_depths(16, 16, 1'b0);
    send_pixel(16'hFFFF, 16'h1234, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'hAAAA, 16'h5555, 16'h0001, 1'b1, 1'b1);

    // Random segments across three idle mixes.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin send_idle_pct = 34; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (seg == SEGMENTS - 1)
        set_depths($urandom_range(31), $urandom_range(31), 1'($urandom_range(1)));
      else
        set_depths(seg_in[seg], seg_out[seg], seg_gray[seg]);
      if (seg == 1 || seg == 8) holds_asked <= holds_asked + 1;
      for (int i = 0; i < SEG_PIXELS; i++) send_random_pixel();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d pixels under %0d depth settings, with color and gray,",
             pixels_sent, settings_used);
    $display("three idle mixes and %0d long output stalls; %0d mismatches seen.",
             holds_done, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("** frc_spatiotemporal_dither: PASSED **");
    end else begin
      $display("** frc_spatiotemporal_dither: FAILED **");
    end
    $finish;
  end

endmodule
